[design/npdt_pkg.sv]
// Shared types, constants and row encoding for the note pattern dedup table.
package npdt_pkg;

	localparam int MAX_PATTERNS_DEF = 256;
	localparam int MAX_ROWS_DEF     = 256;

	localparam int         CFG_W     = 9;
	localparam logic [8:0] RPP_RESET = 9'd64;
	localparam logic [7:0] REST_BYTE = 8'hFF;

	typedef struct packed {
		logic [7:0] note_byte;
		logic [7:0] octave_byte;
	} row_t;

	typedef struct packed {
		logic [7:0] pattern_index;
		logic       is_new;
		logic       store_full;
	} result_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SEARCH,
		B_COPY
	} back_state_t;

	// Gapped semitone table; unused codes give all ones.
	function automatic logic [7:0] note_map(input logic [3:0] idx);
		logic [7:0] v;
		unique case (idx)
			4'd1:    v = 8'd0;
			4'd2:    v = 8'd1;
			4'd3:    v = 8'd2;
			4'd4:    v = 8'd4;
			4'd5:    v = 8'd5;
			4'd6:    v = 8'd6;
			4'd7:    v = 8'd8;
			4'd8:    v = 8'd9;
			4'd9:    v = 8'd10;
			4'd10:   v = 8'd12;
			4'd11:   v = 8'd13;
			4'd12:   v = 8'd14;
			default: v = 8'd255;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] encode_row(input logic [7:0] note, input logic [7:0] octave);
		logic [7:0] v;
		if (note == 8'd0 && octave == 8'd0) begin
			v = REST_BYTE;
		end else begin
			v = {1'b0, octave[2:0], 4'b0000} | note_map(note[3:0]);
		end
		return v;
	endfunction

endpackage

[design/npdt_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module npdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/npdt_queue.sv]
// Two-entry job queue between the row front end and the search back end.
module npdt_queue import npdt_pkg::*; #(
	parameter int WIDTH = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             empty,
	output logic             full
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

`ifndef SYNTH
	// front end must hold off while both scratch banks are queued
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> !full)
		else $error("job queue overflow");
`endif

endmodule

[design/npdt_front.sv]
// Row front end: row count register, row encoding and double-banked scratch fill.
module npdt_front import npdt_pkg::*; #(
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_valid,
	output logic                                          cfg_ready,
	input  logic [CFG_W-1:0]                              cfg_data,
	input  logic                                          accept,
	input  row_t                                          row,
	output logic                                          scr_we,
	output logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1):0]  scr_waddr,
	output logic [7:0]                                    scr_wdata,
	output logic                                          job_push,
	output logic                                          job_bank,
	output logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] job_last
);

	localparam int ROW_W = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;

	logic [CFG_W-1:0] rows_q;
	logic [ROW_W-1:0] pos_q;
	logic             bank_q;
	logic [ROW_W-1:0] last_row;
	logic             row_end;

	assign cfg_ready = 1'b1;

	// zero counts as one row, oversize clamps to the scratch depth
	always_comb begin
		if (rows_q == '0) begin
			last_row = '0;
		end else if (rows_q > CFG_W'(MAX_ROWS)) begin
			last_row = ROW_W'(MAX_ROWS - 1);
		end else begin
			last_row = ROW_W'(rows_q - CFG_W'(1));
		end
	end

	// also ends the pattern when the count shrank below the current row
	assign row_end = (pos_q >= last_row);

	assign scr_we    = accept;
	assign scr_waddr = {bank_q, pos_q};
	assign scr_wdata = encode_row(row.note_byte, row.octave_byte);
	assign job_push  = accept && row_end;
	assign job_bank  = bank_q;
	assign job_last  = last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= RPP_RESET;
			pos_q  <= '0;
			bank_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				rows_q <= cfg_data;
			end
			if (accept) begin
				if (row_end) begin
					pos_q  <= '0;
					bank_q <= ~bank_q;
				end else begin
					pos_q <= pos_q + ROW_W'(1);
				end
			end
		end
	end

endmodule

[design/npdt_back.sv]
// Search and commit back end: row-serial compare against the pattern store.
module npdt_back import npdt_pkg::*; #(
	parameter int MAX_PATTERNS = MAX_PATTERNS_DEF,
	parameter int MAX_ROWS     = MAX_ROWS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          job_valid,
	input  logic                                          job_bank,
	input  logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] job_last,
	output logic                                          job_pop,
	output logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1):0]  scr_raddr,
	input  logic [7:0]                                    scr_rdata,
	output logic                                          done,
	output result_t                                       result
);

	localparam int ROW_W       = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
	localparam int SLOT_W      = MAX_PATTERNS > 1 ? $clog2(MAX_PATTERNS) : 1;
	localparam int COUNT_W     = $clog2(MAX_PATTERNS + 1);
	localparam int STORE_DEPTH = (2 ** SLOT_W) * (2 ** ROW_W);

	back_state_t          state_q, state_d;
	logic [COUNT_W-1:0]   count_q;
	logic [COUNT_W-1:0]   slot_q;
	logic [ROW_W-1:0]     row_q;
	logic                 v_s1;
	logic [COUNT_W-1:0]   slot_s1;
	logic                 last_s1;
	logic                 cp_v_s1;
	logic [ROW_W-1:0]     cp_row_s1;
	logic                 cp_end_q;
	logic                 done_q;
	result_t              res_q;

	logic                 issue;
	logic                 cp_issue;
	logic                 miss;
	logic                 res_load;
	result_t              res_d;
	logic                 start_job;
	logic                 to_copy;
	logic                 commit;
	logic [7:0]           sto_rdata;
	logic                 sto_we;

	npdt_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (sto_we),
		.waddr ({count_q[SLOT_W-1:0], cp_row_s1}),
		.wdata (scr_rdata),
		.raddr ({slot_q[SLOT_W-1:0], row_q}),
		.rdata (sto_rdata)
	);

	assign scr_raddr = {job_bank, row_q};
	assign sto_we    = (state_q == B_COPY) && cp_v_s1;
	assign miss      = v_s1 && (scr_rdata != sto_rdata);

	always_comb begin
		state_d   = state_q;
		issue     = 1'b0;
		cp_issue  = 1'b0;
		res_load  = 1'b0;
		res_d     = '0;
		start_job = 1'b0;
		to_copy   = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					start_job = 1'b1;
					state_d   = B_SEARCH;
				end
			end
			B_SEARCH: begin
				if (v_s1 && !miss && last_s1) begin
					res_load            = 1'b1;
					res_d.pattern_index = 8'(slot_s1);
					state_d             = B_IDLE;
				end else if (miss) begin
					// restart at row zero of the next slot
				end else if (slot_q < count_q) begin
					issue = 1'b1;
				end else if (!v_s1) begin
					if (count_q < COUNT_W'(MAX_PATTERNS)) begin
						to_copy = 1'b1;
						state_d = B_COPY;
					end else begin
						res_load         = 1'b1;
						res_d.store_full = 1'b1;
						state_d          = B_IDLE;
					end
				end
			end
			B_COPY: begin
				cp_issue = !cp_end_q;
				if (cp_end_q && cp_v_s1) begin
					commit              = 1'b1;
					res_load            = 1'b1;
					res_d.pattern_index = 8'(count_q);
					res_d.is_new        = 1'b1;
					state_d             = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	assign job_pop = res_load;
	assign done    = done_q;
	assign result  = res_q;

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
		slot_s1   <= slot_q;
		last_s1   <= (row_q == job_last);
		cp_row_s1 <= row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			count_q  <= '0;
			slot_q   <= '0;
			row_q    <= '0;
			v_s1     <= 1'b0;
			cp_v_s1  <= 1'b0;
			cp_end_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_load;
			v_s1    <= issue;
			cp_v_s1 <= cp_issue;
			if (commit) begin
				count_q <= count_q + COUNT_W'(1);
			end
			if (start_job || to_copy) begin
				slot_q   <= '0;
				row_q    <= '0;
				cp_end_q <= 1'b0;
			end else if (miss) begin
				slot_q <= slot_s1 + COUNT_W'(1);
				row_q  <= '0;
			end else if (issue) begin
				if (row_q == job_last) begin
					row_q  <= '0;
					slot_q <= slot_q + COUNT_W'(1);
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else if (cp_issue) begin
				if (row_q == job_last) begin
					cp_end_q <= 1'b1;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end
		end
	end

`ifndef SYNTH
	a_new_bumps_count: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && res_q.is_new |-> count_q == COUNT_W'($past(count_q) + COUNT_W'(1)))
		else $error("new pattern reported without commit");
`endif
`ifndef SYNTH
	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && res_q.store_full |-> count_q == COUNT_W'(MAX_PATTERNS))
		else $error("store full reported with free slots");
`endif
`ifndef SYNTH
	a_copy_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_COPY |-> count_q < COUNT_W'(MAX_PATTERNS))
		else $error("commit into a full store");
`endif

endmodule

[design/note_pattern_dedup_table.sv]
// Top level of the note pattern deduplication table.
//
// One tracker row (note byte, octave byte) is taken per transfer, at a clock
// edge with start high and busy low, and is encoded straight into a scratch
// pattern: rows stream in at one per cycle while busy stays low. The row that
// completes a pattern of rows_per_pattern rows hands the scratch over to the
// search engine, which compares it row by row against the stored patterns in
// slot order until one matches, one byte per cycle from the store RAM. A slot
// that differs ends at that row and the search restarts at row zero of the
// next slot. When no slot matches, the engine picks between commit and store
// full, and a novel pattern is then copied row by row into the store. The
// scratch has two banks, so a new pattern can be filled while the previous
// one is searched; busy rises only when both banks are waiting. A pattern end
// gives exactly one result, shown on result for a single cycle with done high:
// the receiver cannot stall, so the transfer is taken on that cycle. Other rows
// give none. The store starts empty and needs no clearing pass after reset.
// rows_per_pattern is written over the cfg channel (always ready) and should
// only change while the block is idle; 0 counts as one row and values above
// MAX_ROWS count as MAX_ROWS.
module note_pattern_dedup_table import npdt_pkg::*; #(
	parameter int MAX_PATTERNS = MAX_PATTERNS_DEF,
	parameter int MAX_ROWS     = MAX_ROWS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             start,
	output logic             busy,
	input  row_t             row,
	output logic             done,
	output result_t          result
);

	localparam int ROW_W = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;

	// scratch RAM: bank bit on top, row below
	logic             scr_we;
	logic [ROW_W:0]   scr_waddr;
	logic [7:0]       scr_wdata;
	logic [ROW_W:0]   scr_raddr;
	logic [7:0]       scr_rdata;

	// job hand-over: which bank, and the last row index of the pattern
	logic             job_push;
	logic             job_bank_in;
	logic [ROW_W-1:0] job_last_in;
	logic             job_pop;
	logic [ROW_W:0]   job_head;
	logic             job_empty;
	logic             job_full;
	logic             accept;

	assign busy   = job_full;
	assign accept = start && !busy;

	npdt_front #(
		.MAX_ROWS (MAX_ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.row       (row),
		.scr_we    (scr_we),
		.scr_waddr (scr_waddr),
		.scr_wdata (scr_wdata),
		.job_push  (job_push),
		.job_bank  (job_bank_in),
		.job_last  (job_last_in)
	);

	npdt_ram #(
		.WIDTH (8),
		.DEPTH (2 * (2 ** ROW_W))
	) u_scratch (
		.clk   (clk),
		.we    (scr_we),
		.waddr (scr_waddr),
		.wdata (scr_wdata),
		.raddr (scr_raddr),
		.rdata (scr_rdata)
	);

	npdt_queue #(
		.WIDTH (ROW_W + 1)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data ({job_bank_in, job_last_in}),
		.pop       (job_pop),
		.head      (job_head),
		.empty     (job_empty),
		.full      (job_full)
	);

	npdt_back #(
		.MAX_PATTERNS (MAX_PATTERNS),
		.MAX_ROWS     (MAX_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!job_empty),
		.job_bank  (job_head[ROW_W]),
		.job_last  (job_head[ROW_W-1:0]),
		.job_pop   (job_pop),
		.scr_raddr (scr_raddr),
		.scr_rdata (scr_rdata),
		.done      (done),
		.result    (result)
	);

endmodule

[tb/tb_note_pattern_dedup_table.sv]
// Self-checking testbench for the note pattern deduplication table.
module tb_note_pattern_dedup_table import npdt_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPAT = MAX_PATTERNS_DEF;
	localparam int NROW = MAX_ROWS_DEF;

	// semitone offset per note index; 0 and 13..15 saturate the byte to all ones
	localparam logic [7:0] SEMITONE [16] = '{
		8'hFF, 8'd0, 8'd1, 8'd2, 8'd4, 8'd5, 8'd6, 8'd8,
		8'd9, 8'd10, 8'd12, 8'd13, 8'd14, 8'hFF, 8'hFF, 8'hFF
	};

	typedef enum logic {STEP_ROW, STEP_RPP} step_kind_t;

	// one line of the directed table: either a register write or a run of identical rows
	typedef struct packed {
		step_kind_t       kind;
		logic [CFG_W-1:0] rpp_val;
		row_t             r;
		logic [6:0]       reps;
		logic             typed;   // want holds a result read off by eye
		result_t          want;
	} dir_step_t;

	localparam int N_DIR = 24;

	// Directed opening. Typed results are the ones that are obvious by eye: the
	// all-rest pattern at the reset length lands in slot 0, and with one row per
	// pattern every byte that collapses to all ones finds slot 0 again (note 0,
	// note 13..15, note 0 with a nonzero octave, high bits set but low bits
	// zero). The tail covers a growing count and a count shrunk mid-pattern.
	localparam dir_step_t DIR_TAB [N_DIR] = '{
		'{STEP_ROW, 9'd0, '{8'h00, 8'h00}, 7'd64, 1'b1, '{8'd0, 1'b1, 1'b0}},
		'{STEP_RPP, 9'd0, '{8'h00, 8'h00}, 7'd0,  1'b0, '{8'd0, 1'b0, 1'b0}},
		'{STEP_ROW, 9'd0, '{8'h00, 8'h00}, 7'd1,  1'b1, '{8'd0, 1'b0, 1'b0}},
		'{STEP_ROW, 9'd0, '{8'h01, 8'h00}, 7'd1,  1'b1, '{8'd1, 1'b1, 1'b0}},
		'{STEP_ROW, 9'd0, '{8'h0C, 8'h07}, 7'd1,  1'b1, '{8'd2, 1'b1, 1'b0}},
		'{STEP_ROW, 9'd0, '{8'h0D, 8'h00}, 7'd1,  1'b1, '{8'd0, 1'b0, 1'b0}},
		'{STEP_ROW, 9'd0, '{8'h0E, 8'h03}, 7'd1,  1'b1, '{8'd0, 1'b0, 1'b0}},
		'{STEP_ROW, 9'd0, '{8'h0F, 8'h00}, 7'd1,  1'b1, '{8'd0, 1'b0, 1'b0}},
		'{STEP_ROW, 9'd0, '{8'h00, 8'h05}, 7'd1,  1'b1, '{8'd0, 1'b0, 1'b0}},
		'{STEP_ROW, 9'd0, '{8'hFF, 8'hFF}, 7'd1,  1'b1, '{8'd0, 1'b0, 1'b0}},
		'{STEP_ROW, 9'd0, '{8'h10, 8'h08}, 7'd1,  1'b1, '{8'd0, 1'b0, 1'b0}},
		'{STEP_ROW, 9'd0, '{8'hF1, 8'hF8}, 7'd1,  1'b1, '{8'd1, 1'b0, 1'b0}},
		'{STEP_ROW, 9'd0, '{8'hAC, 8'h57}, 7'd1,  1'b1, '{8'd2, 1'b0, 1'b0}},
		'{STEP_ROW, 9'd0, '{8'h0A, 8'h02}, 7'd1,  1'b0, '{8'd0, 1'b0, 1'b0}},
		'{STEP_ROW, 9'd0, '{8'h07, 8'h04}, 7'd1,  1'b0, '{8'd0, 1'b0, 1'b0}},
		'{STEP_RPP, 9'd2, '{8'h00, 8'h00}, 7'd0,  1'b0, '{8'd0, 1'b0, 1'b0}},
		'{STEP_ROW, 9'd0, '{8'h01, 8'h01}, 7'd1,  1'b0, '{8'd0, 1'b0, 1'b0}},
		'{STEP_ROW, 9'd0, '{8'h02, 8'h01}, 7'd1,  1'b0, '{8'd0, 1'b0, 1'b0}},
		'{STEP_ROW, 9'd0, '{8'h01, 8'h01}, 7'd1,  1'b0, '{8'd0, 1'b0, 1'b0}},
		'{STEP_ROW, 9'd0, '{8'h02, 8'h01}, 7'd1,  1'b0, '{8'd0, 1'b0, 1'b0}},
		'{STEP_RPP, 9'd8, '{8'h00, 8'h00}, 7'd0,  1'b0, '{8'd0, 1'b0, 1'b0}},
		'{STEP_ROW, 9'd0, '{8'h02, 8'h03}, 7'd5,  1'b0, '{8'd0, 1'b0, 1'b0}},
		'{STEP_RPP, 9'd3, '{8'h00, 8'h00}, 7'd0,  1'b0, '{8'd0, 1'b0, 1'b0}},
		'{STEP_ROW, 9'd0, '{8'h09, 8'h06}, 7'd1,  1'b0, '{8'd0, 1'b0, 1'b0}}
	};

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data;
	logic             start;
	logic             busy;
	row_t             row;
	logic             done;
	result_t          result;

	// shadow of the block: register, committed patterns and the pattern being filled
	logic [CFG_W-1:0] rpp_shadow;
	logic [7:0]       store_bytes [NPAT][NROW];
	row_t             store_raw [NPAT][NROW];   // raw rows kept so a pattern can be resent
	int unsigned      slot_rows [NPAT];         // rows written into each slot
	logic [7:0]       scratch_bytes [NROW];
	row_t             scratch_raw [NROW];
	int unsigned      n_slots;
	int unsigned      fill_pos;

	result_t          due_results [$];
	int unsigned      n_err;
	bit               gaps_on;

	note_pattern_dedup_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.start     (start),
		.busy      (busy),
		.row       (row),
		.done      (done),
		.result    (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// effective row count: 0 counts as one row, anything above the scratch depth saturates
	function automatic int unsigned live_rows();
		int unsigned r;
		r = rpp_shadow;
		if (r == 0) r = 1;
		if (r > NROW) r = NROW;
		return r;
	endfunction

	function automatic logic [7:0] pack_note(row_t r);
		if (r.note_byte == 8'd0 && r.octave_byte == 8'd0) return REST_BYTE;
		return {1'b0, r.octave_byte[2:0], 4'b0000} | SEMITONE[r.note_byte[3:0]];
	endfunction

	// Books one accepted row. Returns 1 with the outcome when the row closes a
	// pattern: first identical slot wins, else commit, else report the store full.
	function automatic bit absorb_row(row_t r, output result_t res);
		int unsigned rows;
		int unsigned pos;
		int          hit;
		bit          same;
		rows = live_rows();
		pos  = (fill_pos >= NROW) ? NROW - 1 : fill_pos;
		scratch_bytes[pos] = pack_note(r);
		scratch_raw[pos]   = r;
		res = '0;
		if (pos + 1 < rows) begin
			fill_pos = pos + 1;
			return 1'b0;
		end
		fill_pos = 0;
		hit = -1;
		for (int unsigned s = 0; s < n_slots && hit < 0; s++) begin
			same = 1'b1;
			for (int unsigned k = 0; k < rows && same; k++)
				same = (store_bytes[s][k] == scratch_bytes[k]);
			if (same) hit = s;
		end
		if (hit >= 0) begin
			res.pattern_index = hit[7:0];
		end else if (n_slots < NPAT) begin
			for (int unsigned k = 0; k < rows; k++) begin
				store_bytes[n_slots][k] = scratch_bytes[k];
				store_raw[n_slots][k]   = scratch_raw[k];
			end
			slot_rows[n_slots] = rows;
			res.pattern_index  = n_slots[7:0];
			res.is_new         = 1'b1;
			n_slots++;
		end else begin
			res.store_full = 1'b1;
		end
		return 1'b1;
	endfunction

	// A slot shorter than the current count has nothing written past its end.
	// If the pattern being filled ever matched such a slot over the slot's full
	// length, the search would walk into those unwritten bytes, so that prefix
	// is never completed.
	function automatic bit hits_short_prefix(logic [7:0] b);
		int unsigned rows;
		bit          same;
		rows = live_rows();
		for (int unsigned s = 0; s < n_slots; s++) begin
			if (slot_rows[s] == fill_pos + 1 && slot_rows[s] < rows) begin
				same = (store_bytes[s][fill_pos] == b);
				for (int unsigned k = 0; k < fill_pos && same; k++)
					same = (store_bytes[s][k] == scratch_bytes[k]);
				if (same) return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// full-range bytes, with a fair share of rests (both bytes zero)
	function automatic row_t rand_row();
		row_t r;
		r.note_byte   = 8'($urandom_range(0, 255));
		r.octave_byte = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 7) == 0) r = '0;
		return r;
	endfunction

	function automatic row_t steer_row(row_t r);
		while (hits_short_prefix(pack_note(r))) r = rand_row();
		return r;
	endfunction

	// One row transfer. Drives on the falling edge, sometimes after a short gap,
	// and books the row against the shadow at the accepting rising edge. start
	// stays high after return until the next task's falling edge.
	task automatic send_row(row_t r, bit typed, result_t want);
		result_t res;
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		start <= 1'b1;
		row   <= r;
		do @(posedge clk); while (busy);
		if (absorb_row(r, res)) due_results.push_back(typed ? want : res);
	endtask

	// rows without a result finish at once, so a short pause covers any commit tail
	task automatic drain();
		while (due_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_rpp(logic [CFG_W-1:0] v);
		@(negedge clk);
		start <= 1'b0;
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		rpp_shadow = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One register setting, then whole patterns: either a resend of a stored slot
	// (to provoke a match) or fresh random rows.
	task automatic run_phase(logic [CFG_W-1:0] v, int n_pat, int replay_pct, bit until_full);
		int unsigned rows;
		int unsigned src;
		int          got;
		bit          replay;
		row_t        want;
		write_rpp(v);
		rows = live_rows();
		got  = 0;
		src  = 0;
		while (got < n_pat || (until_full && n_slots < NPAT)) begin
			replay = 1'b0;
			if ($urandom_range(1, 100) <= replay_pct) begin
				for (int t = 0; t < 8 && !replay; t++) begin
					src    = $urandom_range(0, n_slots - 1);
					replay = (slot_rows[src] >= rows);
				end
			end
			for (int unsigned k = 0; k < rows; k++) begin
				want = replay ? store_raw[src][k] : rand_row();
				send_row(steer_row(want), 1'b0, '0);
			end
			got++;
		end
	endtask

	// Result checker: every strobe must meet the oldest expectation.
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (due_results.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("[%0t] result with none due: idx %0d new %0b full %0b",
						$realtime, result.pattern_index, result.is_new, result.store_full);
			end else begin
				want = due_results.pop_front();
				if (result.pattern_index !== want.pattern_index ||
				    result.is_new !== want.is_new || result.store_full !== want.store_full) begin
					n_err++;
					if (n_err <= 10)
						$display("[%0t] mismatch: want idx %0d new %0b full %0b, got idx %0d new %0b full %0b",
							$realtime, want.pattern_index, want.is_new, want.store_full,
							result.pattern_index, result.is_new, result.store_full);
				end
			end
		end
	end

	initial begin : stimulus
		dir_step_t st;
		arst_n     = 1'b0;
		start      = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		row        = '0;
		rpp_shadow = RPP_RESET;
		n_slots    = 0;
		fill_pos   = 0;
		n_err      = 0;
		gaps_on    = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIR; i++) begin
			st = DIR_TAB[i];
			if (st.kind == STEP_RPP)
				write_rpp(st.rpp_val);
			else
				repeat (st.reps) send_row(st.r, st.typed, st.want);
		end

		// all ones in the register saturates to the full scratch depth
		run_phase(9'd511, 1, 0, 1'b0);
		run_phase(9'd4, 15, 35, 1'b0);
		run_phase(9'd1, 40, 30, 1'b0);
		// short patterns until every slot is taken
		run_phase(9'd2, 0, 5, 1'b1);
		// store is full now: novel patterns are refused, resends still match
		gaps_on = 1'b0;
		run_phase(9'd3, 25, 50, 1'b0);

		@(negedge clk);
		start <= 1'b0;
		drain();
		repeat (64) @(posedge clk);
		if (n_err == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// hang guard, well above the slowest legal run
	initial begin : watchdog
		#24ms;
		$display("tb: failure");
		$finish;
	end

endmodule

[sim.f]
design/npdt_pkg.sv
design/npdt_ram.sv
design/npdt_queue.sv
design/npdt_front.sv
design/npdt_back.sv
design/note_pattern_dedup_table.sv
tb/tb_note_pattern_dedup_table.sv
